// File: design/ax25u_pkg.sv
package ax25u_pkg;

  localparam int unsigned CALL_LEN = 6;

  localparam logic [7:0] CTRL_UI    = 8'h03;
  localparam logic [7:0] PID_NO_L3  = 8'hf0;
  localparam logic [6:0] CHAR_SPACE = 7'h20;

  typedef enum logic [4:0] {
    PH_ADDR  = 5'b00001,
    PH_CTRL  = 5'b00010,
    PH_PID   = 5'b00100,
    PH_DATA  = 5'b01000,
    PH_DRAIN = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_SKIP     = 2'd0,
    KIND_CALL     = 2'd1,
    KIND_ADDR_END = 2'd2,
    KIND_PAYLOAD  = 2'd3
  } item_kind_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FORMAT = 3'd1,
    ST_SHORT  = 3'd2,
    ST_UNSUP  = 3'd3,
    ST_LONG   = 3'd4
  } status_t;

  // frame parse state, payload counter lives beside it (its width is a parameter)
  typedef struct packed {
    phase_t      phase;
    logic [2:0]  byte_in_address;
    logic [3:0]  address_count;
    logic        saw_pad_space;
    logic        saw_call_char;
    logic        control_ok;
    status_t     error_code;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:           PH_ADDR,
    byte_in_address: 3'd0,
    address_count:   4'd0,
    saw_pad_space:   1'b0,
    saw_call_char:   1'b0,
    control_ok:      1'b0,
    error_code:      ST_OK
  };

  typedef struct packed {
    item_kind_t  item_kind;
    logic [7:0]  out_data;
    logic [3:0]  addr_index;
    logic [3:0]  ssid_value;
    logic        repeated_flag;
    logic        frame_done;
    status_t     status;
  } result_t;

  function automatic logic is_call_char(input logic [6:0] c);
    logic digit;
    logic upper;
    logic lower;
    digit = (c >= 7'h30) && (c <= 7'h39);
    upper = (c >= 7'h41) && (c <= 7'h5a);
    lower = (c >= 7'h61) && (c <= 7'h7a);
    return digit || upper || lower;
  endfunction

endpackage

// File: design/ax25u_byte_if.sv
interface ax25u_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

// File: design/ax25u_result_if.sv
interface ax25u_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] item_kind;
  logic [7:0] out_data;
  logic [3:0] addr_index;
  logic [3:0] ssid_value;
  logic       repeated_flag;
  logic       frame_done;
  logic [2:0] status;

  modport source (
    output valid, output item_kind, output out_data, output addr_index,
    output ssid_value, output repeated_flag, output frame_done, output status,
    input ready
  );
  modport sink (
    input valid, input item_kind, input out_data, input addr_index,
    input ssid_value, input repeated_flag, input frame_done, input status,
    output ready
  );
endinterface

// File: design/ax25_ui_header_parser.sv
// an accepted byte is held in the input register and then decoded into the result register
// throughput: one byte per cycle while result.ready does not stall the result register,
//   set by the single decode step between the input register and the result register
// reset (rst, synchronous, active high) clears both pipeline valids and returns the
//   parser to the start of a frame; the parser also returns there after every final byte
module ax25_ui_header_parser
  import ax25u_pkg::*;
#(
  parameter int unsigned MAX_ADDRS   = 10,
  parameter int unsigned MAX_PAYLOAD = 256
) (
  input logic            clk,
  input logic            rst,
  ax25u_byte_if.sink     frame,
  ax25u_result_if.source result
);

  localparam int unsigned PCW = $clog2(MAX_PAYLOAD + 1);

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_end;

  // result register
  logic    out_valid;
  result_t out_res;

  // parse state
  state_t         state;
  state_t         state_next;
  logic [PCW-1:0] payload_count;
  logic [PCW-1:0] payload_count_next;
  result_t        res_next;

  logic advance;

  // the input register moves into the result register whenever that one is free
  // or is being emptied in the same cycle; parse state updates on the same edge
  assign advance     = in_valid && (!out_valid || result.ready);
  assign frame.ready = !in_valid || advance;

  ax25u_step #(
    .MAX_ADDRS   (MAX_ADDRS),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_step (
    .state              (state),
    .payload_count      (payload_count),
    .rx_byte            (in_byte),
    .frame_end          (in_end),
    .state_next         (state_next),
    .payload_count_next (payload_count_next),
    .res                (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      out_valid     <= 1'b0;
      state         <= STATE_RESET;
      payload_count <= '0;
    end else begin
      if (frame.ready) begin
        in_valid <= frame.valid;
      end
      if (advance) begin
        out_valid     <= 1'b1;
        state         <= state_next;
        payload_count <= payload_count_next;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers, qualified by the valids above
  always_ff @(posedge clk) begin
    if (frame.valid && frame.ready) begin
      in_byte <= frame.rx_byte;
      in_end  <= frame.frame_end;
    end
    if (advance) begin
      out_res <= res_next;
    end
  end

  assign result.valid         = out_valid;
  assign result.item_kind     = out_res.item_kind;
  assign result.out_data      = out_res.out_data;
  assign result.addr_index    = out_res.addr_index;
  assign result.ssid_value    = out_res.ssid_value;
  assign result.repeated_flag = out_res.repeated_flag;
  assign result.frame_done    = out_res.frame_done;
  assign result.status        = out_res.status;

  // a final byte always leaves the parser at the start of a fresh frame
  a_end_resets : assert property (@(posedge clk) disable iff (rst)
    (advance && in_end) |=> (state == STATE_RESET && payload_count == '0))
    else $error("parser state not cleared after final byte");

  // status is only reported with the final byte
  a_status_on_done : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_res.frame_done) |-> (out_res.status == ST_OK))
    else $error("status reported before frame end");

  // drain phase is only entered by latching an error
  a_drain_has_error : assert property (@(posedge clk) disable iff (rst)
    (state.phase == PH_DRAIN) |-> (state.error_code != ST_OK))
    else $error("drain phase without an error");

  a_payload_bound : assert property (@(posedge clk) disable iff (rst)
    payload_count <= PCW'(MAX_PAYLOAD))
    else $error("payload counter past limit");

  // a byte taken while draining never produces a decoded item
  a_error_kind : assert property (@(posedge clk) disable iff (rst)
    (advance && state.phase == PH_DRAIN) |=> (out_res.item_kind == KIND_SKIP))
    else $error("decoded item while draining");

endmodule

// File: design/ax25u_step.sv
module ax25u_step
  import ax25u_pkg::*;
#(
  parameter int unsigned MAX_ADDRS   = 10,
  parameter int unsigned MAX_PAYLOAD = 256,
  localparam int unsigned PCW        = $clog2(MAX_PAYLOAD + 1)
) (
  input  state_t         state,
  input  logic [PCW-1:0] payload_count,
  input  logic [7:0]     rx_byte,
  input  logic           frame_end,
  output state_t         state_next,
  output logic [PCW-1:0] payload_count_next,
  output result_t        res
);

  logic [6:0] c;
  logic [3:0] count_inc;

  assign c         = rx_byte[7:1];
  assign count_inc = state.address_count + 4'd1;

  always_comb begin
    state_next         = state;
    payload_count_next = payload_count;
    res                = '0;

    unique case (state.phase)
      PH_ADDR: begin
        if (state.byte_in_address < 3'(CALL_LEN)) begin
          if (c == CHAR_SPACE) begin
            state_next.saw_pad_space   = 1'b1;
            state_next.byte_in_address = state.byte_in_address + 3'd1;
            res.item_kind              = KIND_CALL;
            res.out_data               = {1'b0, c};
            res.addr_index             = state.address_count;
          end else if (!is_call_char(c) || state.saw_pad_space) begin
            state_next.error_code = ST_FORMAT;
            state_next.phase      = PH_DRAIN;
          end else begin
            state_next.saw_call_char   = 1'b1;
            state_next.byte_in_address = state.byte_in_address + 3'd1;
            res.item_kind              = KIND_CALL;
            res.out_data               = {1'b0, c};
            res.addr_index             = state.address_count;
          end
        end else if (!state.saw_call_char) begin
          // all-space callsign
          state_next.error_code = ST_FORMAT;
          state_next.phase      = PH_DRAIN;
        end else begin
          state_next.address_count   = count_inc;
          state_next.byte_in_address = 3'd0;
          state_next.saw_pad_space   = 1'b0;
          state_next.saw_call_char   = 1'b0;
          if (rx_byte[0] && (count_inc < 4'd2)) begin
            // destination flagged as last address
            state_next.error_code = ST_FORMAT;
            state_next.phase      = PH_DRAIN;
          end else if (!rx_byte[0] && (count_inc >= 4'(MAX_ADDRS))) begin
            state_next.error_code = ST_FORMAT;
            state_next.phase      = PH_DRAIN;
          end else begin
            if (rx_byte[0]) begin
              state_next.phase = PH_CTRL;
            end
            res.item_kind     = KIND_ADDR_END;
            res.addr_index    = state.address_count;
            res.ssid_value    = rx_byte[4:1];
            res.repeated_flag = (state.address_count >= 4'd2) && rx_byte[7];
          end
        end
      end
      PH_CTRL: begin
        state_next.control_ok = (rx_byte == CTRL_UI);
        state_next.phase      = PH_PID;
      end
      PH_PID: begin
        if (state.control_ok && (rx_byte == PID_NO_L3)) begin
          state_next.phase = PH_DATA;
        end else begin
          state_next.error_code = ST_UNSUP;
          state_next.phase      = PH_DRAIN;
        end
      end
      PH_DATA: begin
        if (payload_count < PCW'(MAX_PAYLOAD)) begin
          payload_count_next = payload_count + PCW'(1);
          res.item_kind      = KIND_PAYLOAD;
          res.out_data       = rx_byte;
        end else begin
          state_next.error_code = ST_LONG;
          state_next.phase      = PH_DRAIN;
        end
      end
      PH_DRAIN: begin
      end
      default: begin
      end
    endcase

    if (frame_end) begin
      res.frame_done = 1'b1;
      if (state.error_code != ST_OK) begin
        res.status = state.error_code;
      end else if (state_next.error_code != ST_OK) begin
        res.status = state_next.error_code;
      end else if (state_next.phase == PH_ADDR) begin
        res.status = ST_FORMAT;
      end else if (state_next.phase == PH_CTRL || state_next.phase == PH_PID) begin
        res.status = ST_SHORT;
      end else begin
        res.status = ST_OK;
      end
      state_next         = STATE_RESET;
      payload_count_next = '0;
    end
  end

endmodule
